>>> hdl/srau_pkg.sv
// Package with shared types and constants for the signed rational arithmetic unit.
package srau_pkg;
  localparam int OPERAND_WIDTH = 32;
  localparam int IN_W  = 32;
  localparam int RES_W = 64;

  localparam logic [1:0] MODE_MUL = 2'd0;
  localparam logic [1:0] MODE_DIV = 2'd1;
  localparam logic [1:0] MODE_ADD = 2'd2;
  localparam logic [1:0] MODE_SUB = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_ZDEN = 2'd2;

  typedef struct packed {
    logic [1:0]      mode;
    logic [IN_W-1:0] a_num;
    logic [IN_W-1:0] a_den;
    logic            a_neg;
    logic [IN_W-1:0] b_num;
    logic [IN_W-1:0] b_den;
    logic            b_neg;
  } in_item_t;

  typedef struct packed {
    logic [RES_W-1:0] res_num;
    logic [RES_W-1:0] res_den;
    logic             res_neg;
    logic [1:0]       status;
  } out_item_t;

  // Classified job passed from the front part to the back part.
  typedef struct packed {
    logic [1:0]               mode;
    logic                     zden;
    logic [OPERAND_WIDTH-1:0] an;
    logic [OPERAND_WIDTH-1:0] ad;
    logic                     as;
    logic [OPERAND_WIDTH-1:0] bn;
    logic [OPERAND_WIDTH-1:0] bd;
    logic                     bs;
  } job_t;
endpackage

>>> hdl/srau_front.sv
// Front part: accepts items, masks operands, flags zero denominators, queues jobs.
module srau_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  srau_pkg::in_item_t item,
  output logic               job_valid,
  input  logic               job_take,
  output srau_pkg::job_t     job
);
  localparam int W = srau_pkg::OPERAND_WIDTH;
  srau_pkg::job_t q_r [2];
  logic [1:0] cnt_r;
  logic       wp_r, rp_r;
  srau_pkg::job_t nj;
  logic wr, rd;

  always_comb begin
    nj.mode = item.mode;
    nj.an = item.a_num[W-1:0];
    nj.ad = item.a_den[W-1:0];
    nj.as = item.a_neg;
    nj.bn = item.b_num[W-1:0];
    nj.bd = item.b_den[W-1:0];
    nj.bs = item.b_neg;
    nj.zden = (nj.ad == '0) || (nj.bd == '0) ||
              ((item.mode == srau_pkg::MODE_DIV) && (nj.bn == '0));
  end

  assign full = (cnt_r == 2'd2);
  assign job_valid = (cnt_r != 2'd0);
  assign job = q_r[rp_r];
  assign wr = push && !full;
  assign rd = job_take && job_valid;

  always_ff @(posedge clk) begin
    if (wr) q_r[wp_r] <= nj;
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

>>> hdl/srau_divider.sv
// Iterative 64-bit unsigned divider, one quotient bit per cycle.
module srau_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quot,
  output logic [63:0] rem
);
  logic [63:0] q_r, d_r;
  logic [64:0] r_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic [64:0] sh, diff;

  assign sh   = {r_r[63:0], q_r[63]};
  assign diff = sh - {1'b0, d_r};
  assign quot = q_r;
  assign rem  = r_r[63:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done <= 1'b0; cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q_r <= dividend; d_r <= divisor; r_r <= '0;
        cnt_r <= 7'd64; busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!diff[64]) begin
          r_r <= diff; q_r <= {q_r[62:0], 1'b1};
        end else begin
          r_r <= sh; q_r <= {q_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0; done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> hdl/srau_back.sv
// Back part: products, add/subtract, GCD reduction and the result register.
module srau_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  output logic                job_take,
  input  srau_pkg::job_t      job,
  output logic                empty,
  input  logic                pop,
  output srau_pkg::out_item_t res
);
  localparam int W = srau_pkg::OPERAND_WIDTH;
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_SUM, S_GCD, S_DN, S_DD, S_OUT} st_t;
  st_t st_r;
  srau_pkg::job_t j_r;
  logic [63:0] p_r, q_r, den_r, num_r, x_r, y_r, g_r;
  logic        neg_r;
  logic        dstart_r;
  logic        dwait_r;
  logic        ddone;
  logic [63:0] dq, drem, dvd, dvs;
  logic [64:0] sum;
  logic        addm;
  logic        full_r;
  logic [63:0] m1, m2, m3;

  assign m1 = {{(64-W){1'b0}}, j_r.an} * {{(64-W){1'b0}}, j_r.bd};
  assign m2 = {{(64-W){1'b0}}, j_r.bn} * {{(64-W){1'b0}}, j_r.ad};
  assign m3 = (j_r.mode == srau_pkg::MODE_DIV) ?
              {{(64-W){1'b0}}, j_r.ad} * {{(64-W){1'b0}}, j_r.bn} :
              {{(64-W){1'b0}}, j_r.ad} * {{(64-W){1'b0}}, j_r.bd};
  assign sum  = {1'b0, p_r} + {1'b0, q_r};
  assign addm = (j_r.mode == srau_pkg::MODE_ADD) ? (j_r.as == j_r.bs) : (j_r.as != j_r.bs);
  assign job_take = (st_r == S_IDLE) && !full_r;
  assign empty = !full_r;

  always_comb begin
    unique case (st_r)
      S_GCD:   begin dvd = x_r;   dvs = y_r; end
      S_DN:    begin dvd = num_r; dvs = g_r; end
      default: begin dvd = den_r; dvs = g_r; end
    endcase
  end

  srau_divider u_div (.clk(clk), .rst_n(rst_n), .start(dstart_r), .dividend(dvd),
    .divisor(dvs), .done(ddone), .quot(dq), .rem(drem));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; full_r <= 1'b0; dstart_r <= 1'b0; dwait_r <= 1'b0;
    end else begin
      dstart_r <= 1'b0;
      if (pop && full_r) full_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (job_valid && !full_r) begin
          j_r <= job; st_r <= S_MUL;
        end
        S_MUL: begin
          p_r <= m1; q_r <= m2; den_r <= m3; st_r <= S_SUM;
          if (j_r.zden) begin
            res <= {64'd0, 64'd0, 1'b0, srau_pkg::ST_ZDEN}; st_r <= S_OUT;
          end
        end
        S_SUM: begin
          if (j_r.mode == srau_pkg::MODE_MUL || j_r.mode == srau_pkg::MODE_DIV) begin
            res <= {(j_r.mode == srau_pkg::MODE_MUL) ?
                    ({{(64-W){1'b0}}, j_r.an} * {{(64-W){1'b0}}, j_r.bn}) : p_r,
                    den_r, j_r.as ^ j_r.bs, srau_pkg::ST_OK};
            st_r <= S_OUT;
          end else if (addm && sum[64]) begin
            res <= {64'd0, 64'd0, 1'b0, srau_pkg::ST_OVF}; st_r <= S_OUT;
          end else begin
            if (addm) begin
              num_r <= sum[63:0]; y_r <= sum[63:0]; neg_r <= j_r.as;
            end else if (p_r >= q_r) begin
              num_r <= p_r - q_r; y_r <= p_r - q_r; neg_r <= j_r.as;
            end else begin
              num_r <= q_r - p_r; y_r <= q_r - p_r;
              neg_r <= (j_r.mode == srau_pkg::MODE_ADD) ? j_r.bs : ~j_r.as;
            end
            x_r <= den_r; st_r <= S_GCD;
          end
        end
        S_GCD: begin
          // One remainder step at a time; dwait_r covers the divider's run.
          if (ddone) begin
            x_r <= y_r; y_r <= drem; dwait_r <= 1'b0;
          end else if (!dwait_r) begin
            if (y_r != 64'd0) begin
              dstart_r <= 1'b1; dwait_r <= 1'b1;
            end else begin
              g_r <= (x_r == 64'd0) ? 64'd1 : x_r; st_r <= S_DN; dstart_r <= 1'b1;
            end
          end
        end
        S_DN: if (ddone) begin
          num_r <= dq; st_r <= S_DD; dstart_r <= 1'b1;
        end
        S_DD: if (ddone) begin
          res <= {num_r, dq, neg_r, srau_pkg::ST_OK}; st_r <= S_OUT;
        end
        S_OUT: begin full_r <= 1'b1; st_r <= S_IDLE; end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hdl/signed_rational_arithmetic_unit.sv
// Top level of the signed rational arithmetic unit.
// Items enter through a queue-style port: an item is taken when in_push is
// high and in_full is low. A front part masks the operands, flags zero
// denominators and places the item into a two-entry job queue.
// A back part forms the cross products with 32x32 multipliers, selects
// the sum or difference, and reduces add and subtract results by a
// Euclidean GCD built on one shared 64-bit divider that produces one
// quotient bit per cycle.
// Multiply, divide and overflow items pass through states S_MUL, S_SUM
// and S_OUT after they are accepted, zero-denominator items through S_MUL
// and S_OUT. Add and subtract run one divider operation per GCD step
// plus two divisions for the reduction.
// The result waits on out_item while out_empty is low and leaves when
// out_pop is high. While a result waits, the back part holds and the
// front queue still takes up to two more items.
// Synchronous active-low reset empties both queues and idles the back part.
module signed_rational_arithmetic_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  srau_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output srau_pkg::out_item_t out_item
);
  logic           job_valid, job_take;
  srau_pkg::job_t job;

  srau_front u_front (.clk(clk), .rst_n(rst_n), .push(in_push), .full(in_full),
    .item(in_item), .job_valid(job_valid), .job_take(job_take), .job(job));

  srau_back u_back (.clk(clk), .rst_n(rst_n), .job_valid(job_valid),
    .job_take(job_take), .job(job), .empty(out_empty), .pop(out_pop),
    .res(out_item));
endmodule

>>> dv/signed_rational_arithmetic_unit_test.sv
// Self-checking testbench for the signed rational arithmetic unit.
`timescale 1ns / 1ps

module signed_rational_arithmetic_unit_test;

  localparam int NUM_RANDOM   = 1850;
  localparam int CYCLE_LIMIT  = 50000000;
  localparam int LONG_HOLD    = 400;

  logic                clk;
  logic                rst_n;
  logic                in_push;
  logic                in_full;
  srau_pkg::in_item_t  in_item;
  logic                out_empty;
  logic                out_pop;
  srau_pkg::out_item_t out_item;

  signed_rational_arithmetic_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  // Items waiting to be offered, and results the block still owes us.
  srau_pkg::in_item_t  pending_items[$];
  srau_pkg::out_item_t expected_results[$];
  int        fail_count;
  int        items_sent;
  int        results_checked;
  int        cycle_count;
  int        mode_seen[4];
  int        status_seen[3];
  bit        stimulus_done;
  bit        hold_now;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Euclid on 64-bit values, as the block reduces add and subtract results.
  function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
    logic [63:0] r;
    while (y != 64'd0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  // Computes the rational result of one item.
  function automatic srau_pkg::out_item_t rational_result(srau_pkg::in_item_t it);
    srau_pkg::out_item_t res;
    logic [63:0] an, ad, bn, bd, p, q, num, den, g;
    logic [64:0] wide_sum;
    logic        neg, add_mag;
    an = 64'(it.a_num[srau_pkg::OPERAND_WIDTH-1:0]);
    ad = 64'(it.a_den[srau_pkg::OPERAND_WIDTH-1:0]);
    bn = 64'(it.b_num[srau_pkg::OPERAND_WIDTH-1:0]);
    bd = 64'(it.b_den[srau_pkg::OPERAND_WIDTH-1:0]);
    res = '0;
    if (ad == 0 || bd == 0) begin
      res.status = srau_pkg::ST_ZDEN;
      return res;
    end
    case (it.mode)
      srau_pkg::MODE_MUL: begin
        res.res_num = an * bn;
        res.res_den = ad * bd;
        res.res_neg = it.a_neg ^ it.b_neg;
        res.status  = srau_pkg::ST_OK;
        return res;
      end
      srau_pkg::MODE_DIV: begin
        if (bn == 0) begin
          res.status = srau_pkg::ST_ZDEN;
          return res;
        end
        res.res_num = an * bd;
        res.res_den = ad * bn;
        res.res_neg = it.a_neg ^ it.b_neg;
        res.status  = srau_pkg::ST_OK;
        return res;
      end
      default: ;
    endcase
    p = an * bd;
    q = bn * ad;
    den = ad * bd;
    add_mag = (it.mode == srau_pkg::MODE_ADD) ? (it.a_neg == it.b_neg) :
                                                (it.a_neg != it.b_neg);
    if (add_mag) begin
      wide_sum = {1'b0, p} + {1'b0, q};
      if (wide_sum[64]) begin
        res.status = srau_pkg::ST_OVF;
        return res;
      end
      num = wide_sum[63:0];
      neg = it.a_neg;
    end else if (p >= q) begin
      num = p - q;
      neg = it.a_neg;
    end else begin
      num = q - p;
      neg = (it.mode == srau_pkg::MODE_ADD) ? it.b_neg : ~it.a_neg;
    end
    g = euclid_gcd(den, num);
    if (g == 0) g = 64'd1;
    res.res_num = num / g;
    res.res_den = den / g;
    res.res_neg = neg;
    res.status  = srau_pkg::ST_OK;
    return res;
  endfunction

  function automatic srau_pkg::in_item_t make_item(logic [1:0] mode, logic [31:0] an,
                                                   logic [31:0] ad, logic an_neg,
                                                   logic [31:0] bn, logic [31:0] bd,
                                                   logic bn_neg);
    srau_pkg::in_item_t it;
    it.mode  = mode;
    it.a_num = an;
    it.a_den = ad;
    it.a_neg = an_neg;
    it.b_num = bn;
    it.b_den = bd;
    it.b_neg = bn_neg;
    return it;
  endfunction

  // Operand magnitudes: mostly small so the GCD loop stays short, with some
  // full-width values so every bit toggles and overflow can happen.
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'($urandom_range(0, 20));
      4, 5:       return 32'($urandom_range(0, 1000));
      6:          return 32'($urandom_range(0, 65535));
      7:          return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
      default:    return $urandom();
    endcase
  endfunction

  // Denominators are rarely zero, so most items reach the arithmetic.
  function automatic logic [31:0] rand_den();
    if ($urandom_range(0, 29) == 0) return 32'd0;
    return rand_operand() | 32'($urandom_range(0, 1) == 0);
  endfunction

  // Directed items first, then random ones.
  initial begin
    srau_pkg::in_item_t it;
    stimulus_done = 1'b0;
    for (int m = 0; m < 4; m++) begin
      pending_items.push_back(make_item(2'(m), 32'd3, 32'd4, 1'b0, 32'd5, 32'd6, 1'b1));
      pending_items.push_back(make_item(2'(m), 32'd7, 32'd0, 1'b1, 32'd2, 32'd3, 1'b0));
      pending_items.push_back(make_item(2'(m), 32'd0, 32'd9, 1'b1, 32'd0, 32'd4, 1'b0));
    end
    // Zero second numerator in divide, equal magnitudes, like-sign
    // overflow, full-width operands, and both difference branches.
    pending_items.push_back(make_item(srau_pkg::MODE_DIV, 32'd5, 32'd2, 1'b0, 32'd0, 32'd3,
                                      1'b1));
    pending_items.push_back(make_item(srau_pkg::MODE_ADD, 32'd1, 32'd2, 1'b1, 32'd2, 32'd4,
                                      1'b0));
    pending_items.push_back(make_item(srau_pkg::MODE_SUB, 32'd3, 32'd6, 1'b0, 32'd1, 32'd2,
                                      1'b0));
    pending_items.push_back(make_item(srau_pkg::MODE_ADD, '1, '1, 1'b0, '1, '1, 1'b0));
    pending_items.push_back(make_item(srau_pkg::MODE_SUB, '1, 32'd1, 1'b1, '1, 32'd1, 1'b0));
    pending_items.push_back(make_item(srau_pkg::MODE_ADD, '1, 32'h8000_0000, 1'b0, '1, 32'd1,
                                      1'b0));
    pending_items.push_back(make_item(srau_pkg::MODE_MUL, '1, '1, 1'b1, '1, '1, 1'b1));
    pending_items.push_back(make_item(srau_pkg::MODE_DIV, '1, '1, 1'b0, '1, '1, 1'b1));
    pending_items.push_back(make_item(srau_pkg::MODE_ADD, 32'd1, 32'd3, 1'b0, 32'd2, 32'd3,
                                      1'b1));
    pending_items.push_back(make_item(srau_pkg::MODE_SUB, 32'd1, 32'd3, 1'b1, 32'd2, 32'd3,
                                      1'b1));
    pending_items.push_back(make_item(srau_pkg::MODE_SUB, 32'd2, 32'd3, 1'b0, 32'd1, 32'd3,
                                      1'b1));
    for (int i = 0; i < NUM_RANDOM; i++) begin
      it.mode  = 2'($urandom_range(0, 3));
      it.a_num = rand_operand();
      it.a_den = rand_den();
      it.a_neg = 1'($urandom_range(0, 1));
      it.b_num = rand_operand();
      it.b_den = rand_den();
      it.b_neg = 1'($urandom_range(0, 1));
      // Now and then make the magnitudes equal to hit a zero difference.
      if ($urandom_range(0, 15) == 0) begin
        it.b_num = it.a_num;
        it.b_den = it.a_den;
      end
      pending_items.push_back(it);
    end
    stimulus_done = 1'b1;
  end

  // Sender: offers items from the queue, with a random gap before each.
  int send_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push  <= 1'b0;
      in_item  <= '0;
      send_gap <= 0;
    end else begin
      if (in_push && !in_full) begin
        // The item on the port was taken at this edge.
        expected_results.push_back(rational_result(in_item));
        mode_seen[in_item.mode]++;
        items_sent++;
      end
      if (in_push && in_full) begin
        // Keep offering the same item until it is taken.
      end else if (send_gap > 0) begin
        in_push  <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_items.size() > 0) begin
        in_push  <= 1'b1;
        in_item  <= pending_items.pop_front();
        // Long stretches without idling come from the zero draws.
        send_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Receiver hold-off: one long stall early in the run so the job queue
  // fills and the sender sees in_full, plus a random wait per result.
  int hold_count;
  int pop_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_count <= 0;
      hold_now   <= 1'b0;
    end else if (items_sent == 30 && hold_count == 0 && !hold_now) begin
      hold_now   <= 1'b1;
      hold_count <= LONG_HOLD;
    end else if (hold_now) begin
      if (hold_count == 1) hold_now <= 1'b0;
      hold_count <= hold_count - 1;
    end
  end

  // Monitor: checks each popped result against the oldest expectation.
  always @(posedge clk) begin
    out_result_check();
  end

  task automatic out_result_check();
    srau_pkg::out_item_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_gap <= 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: %p", $time, out_item);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_item.res_num !== want.res_num || out_item.res_den !== want.res_den ||
              out_item.res_neg !== want.res_neg || out_item.status !== want.status) begin
            $display("%0t: mismatch expected num=%0d den=%0d neg=%0b st=%0d", $time,
                     want.res_num, want.res_den, want.res_neg, want.status);
            $display("%0t:          actual   num=%0d den=%0d neg=%0b st=%0d", $time,
                     out_item.res_num, out_item.res_den, out_item.res_neg, out_item.status);
            fail_count++;
          end
          if (want.status <= srau_pkg::ST_ZDEN) status_seen[want.status]++;
          results_checked++;
        end
      end
      // Pop one result at a time, then draw a new wait.
      if (out_pop && !out_empty) begin
        out_pop <= 1'b0;
        pop_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
      end else if (hold_now || pop_gap > 0) begin
        out_pop <= 1'b0;
        if (pop_gap > 0) pop_gap <= pop_gap - 1;
      end else begin
        out_pop <= 1'b1;
      end
    end
  endtask

  // Reset, then wait for the stimulus to drain and all results to arrive.
  initial begin
    fail_count      = 0;
    items_sent      = 0;
    results_checked = 0;
    rst_n           = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!(stimulus_done && pending_items.size() == 0 && !in_push &&
             expected_results.size() == 0)) begin
      @(posedge clk);
    end
    repeat (50) @(posedge clk);
    $display("Run covered %0d items: mul %0d, div %0d, add %0d, sub %0d.", items_sent,
             mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3]);
    $display("Results checked %0d: ok %0d, overflow %0d, zero denominator %0d.",
             results_checked, status_seen[0], status_seen[1], status_seen[2]);
    if (fail_count == 0) begin
      $display("** signed_rational_arithmetic_unit: PASSED **");
    end else begin
      $display("** signed_rational_arithmetic_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog on the cycle count.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
    $display("** signed_rational_arithmetic_unit: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
hdl/srau_pkg.sv
hdl/srau_front.sv
hdl/srau_divider.sv
hdl/srau_back.sv
hdl/signed_rational_arithmetic_unit.sv
dv/signed_rational_arithmetic_unit_test.sv
